/* rtl/core/glpd_pkg.sv */
`default_nettype none
package glpd_pkg;
   localparam int MAX_ROWS    = 128;
   localparam int MAX_COLS    = 128;
   localparam int HEIGHT_BITS = 16;
   localparam int DIM_BITS    = 8;
   localparam int ROW_BITS    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_BITS    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CELL_DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_BITS   = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
   localparam int CNT_BITS    = ADDR_BITS + 1;
   localparam int RUN_BITS    = 15;
   localparam int IN_BITS     = 16;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] REG_ROWS = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_COLS = 1'd1;

   typedef struct packed {
      logic [DIM_BITS-1:0] rows;
      logic [DIM_BITS-1:0] cols;
   } dims_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [RUN_BITS-1:0] best;
   } srch_status_type;

   function automatic logic [ADDR_BITS-1:0] cell_addr(
      input logic [ROW_BITS-1:0] r,
      input logic [COL_BITS-1:0] c,
      input logic [DIM_BITS-1:0] cols);
      logic [ADDR_BITS+DIM_BITS-1:0] p;
      p = (ADDR_BITS+DIM_BITS)'(r) * (ADDR_BITS+DIM_BITS)'(cols)
        + (ADDR_BITS+DIM_BITS)'(c);
      return p[ADDR_BITS-1:0];
   endfunction

   function automatic logic [DIM_BITS-1:0] clamp_dim(
      input logic [DIM_BITS-1:0] v,
      input logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] r;
      r = v;
      if (v == '0) r = DIM_BITS'(1);
      else if (v > hi) r = hi;
      return r;
   endfunction
endpackage
`default_nettype wire

/* rtl/core/glpd_ram.sv */
`default_nettype none
module glpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

/* rtl/core/glpd_search.sv */
`default_nettype none
module glpd_search (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            go,
   input  wire glpd_pkg::dims_type              dims,
   input  wire logic                            ld_we,
   input  wire logic [glpd_pkg::ADDR_BITS-1:0]  ld_addr,
   input  wire logic [glpd_pkg::HEIGHT_BITS-1:0] ld_height,
   output glpd_pkg::srch_status_type            status
);
   import glpd_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SRD  = 4'd1;
   localparam logic [3:0] ST_SCHK = 4'd2;
   localparam logic [3:0] ST_WCUR = 4'd3;
   localparam logic [3:0] ST_WCH  = 4'd4;
   localparam logic [3:0] ST_WNB  = 4'd5;
   localparam logic [3:0] ST_WNBD = 4'd6;
   localparam logic [3:0] ST_WFIN = 4'd7;
   localparam logic [3:0] ST_WPOP = 4'd8;
   localparam logic [3:0] ST_DONE = 4'd9;

   logic [3:0]                   state_ff, state_in;
   logic [ROW_BITS-1:0]          ri_ff, ri_in, cr_ff, cr_in;
   logic [COL_BITS-1:0]          ci_ff, ci_in, cc_ff, cc_in;
   logic signed [HEIGHT_BITS-1:0] hcur_ff, hcur_in;
   logic [1:0]                   k_ff, k_in;
   logic [RUN_BITS-1:0]          longest_ff, longest_in, best_ff, best_in;
   logic [CNT_BITS-1:0]          sp_ff, sp_in;

   logic [DIM_BITS-1:0]  nr8, nc8;
   logic                 nb_ok;
   logic [ROW_BITS-1:0]  ar;
   logic [COL_BITS-1:0]  ac;
   logic [ADDR_BITS-1:0] addr;
   logic                 cell_we, stk_we;
   logic [ADDR_BITS-1:0] cell_waddr, stk_waddr, stk_raddr;
   logic [HEIGHT_BITS+RUN_BITS-1:0] cell_wdata, cell_rdata;
   logic signed [HEIGHT_BITS-1:0] h_rdata;
   logic [RUN_BITS-1:0]  run_rdata;
   logic [ROW_BITS+COL_BITS-1:0] stk_rdata;
   logic                 last_cell;

   always_comb begin
      nr8   = DIM_BITS'(cr_ff);
      nc8   = DIM_BITS'(cc_ff);
      nb_ok = 1'b0;
      case (k_ff)
         2'd0: begin
            nc8   = DIM_BITS'(cc_ff) + DIM_BITS'(1);
            nb_ok = nc8 < dims.cols;
         end
         2'd1: begin
            nr8   = DIM_BITS'(cr_ff) - DIM_BITS'(1);
            nb_ok = cr_ff != '0;
         end
         2'd2: begin
            nc8   = DIM_BITS'(cc_ff) - DIM_BITS'(1);
            nb_ok = cc_ff != '0;
         end
         default: begin
            nr8   = DIM_BITS'(cr_ff) + DIM_BITS'(1);
            nb_ok = nr8 < dims.rows;
         end
      endcase
   end

   always_comb begin
      ar = cr_ff;
      ac = cc_ff;
      if (state_ff == ST_WNB) begin
         ar = nr8[ROW_BITS-1:0];
         ac = nc8[COL_BITS-1:0];
      end else if (state_ff == ST_SRD) begin
         ar = ri_ff;
         ac = ci_ff;
      end
   end

   assign addr      = cell_addr(ar, ac, dims.cols);
   assign h_rdata   = cell_rdata[HEIGHT_BITS+RUN_BITS-1:RUN_BITS];
   assign run_rdata = cell_rdata[RUN_BITS-1:0];
   assign last_cell = (DIM_BITS'(ri_ff) == dims.rows - DIM_BITS'(1))
                   && (DIM_BITS'(ci_ff) == dims.cols - DIM_BITS'(1));

   always_comb begin
      state_in   = state_ff;
      ri_in      = ri_ff;
      ci_in      = ci_ff;
      cr_in      = cr_ff;
      cc_in      = cc_ff;
      hcur_in    = hcur_ff;
      k_in       = k_ff;
      longest_in = longest_ff;
      best_in    = best_ff;
      sp_in      = sp_ff;
      cell_we    = 1'b0;
      cell_waddr = addr;
      cell_wdata = {hcur_ff, longest_ff + RUN_BITS'(1)};
      stk_we     = 1'b0;
      stk_waddr  = sp_ff[ADDR_BITS-1:0];
      stk_raddr  = sp_ff[ADDR_BITS-1:0] - ADDR_BITS'(1);
      case (state_ff)
         ST_IDLE: begin
            if (ld_we) begin
               cell_we    = 1'b1;
               cell_waddr = ld_addr;
               cell_wdata = {ld_height, RUN_BITS'(0)};
            end
            if (go) begin
               ri_in    = '0;
               ci_in    = '0;
               best_in  = '0;
               state_in = ST_SRD;
            end
         end
         ST_SRD: begin
            state_in = ST_SCHK;
         end
         ST_SCHK: begin
            if (run_rdata == '0) begin
               cr_in    = ri_ff;
               cc_in    = ci_ff;
               sp_in    = '0;
               state_in = ST_WCUR;
            end else begin
               if (run_rdata > best_ff) best_in = run_rdata;
               if (last_cell) begin
                  state_in = ST_DONE;
               end else begin
                  if (DIM_BITS'(ci_ff) == dims.cols - DIM_BITS'(1)) begin
                     ci_in = '0;
                     ri_in = ri_ff + ROW_BITS'(1);
                  end else begin
                     ci_in = ci_ff + COL_BITS'(1);
                  end
                  state_in = ST_SRD;
               end
            end
         end
         ST_WCUR: begin
            state_in = ST_WCH;
         end
         ST_WCH: begin
            hcur_in    = h_rdata;
            k_in       = '0;
            longest_in = '0;
            state_in   = ST_WNB;
         end
         ST_WNB: begin
            if (nb_ok) begin
               state_in = ST_WNBD;
            end else if (k_ff == 2'd3) begin
               state_in = ST_WFIN;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_WNBD: begin
            if ((h_rdata < hcur_ff) && (run_rdata == '0)) begin
               stk_we     = 1'b1;
               sp_in      = sp_ff + CNT_BITS'(1);
               cr_in      = nr8[ROW_BITS-1:0];
               cc_in      = nc8[COL_BITS-1:0];
               hcur_in    = h_rdata;
               k_in       = '0;
               longest_in = '0;
               state_in   = ST_WNB;
            end else begin
               if ((h_rdata < hcur_ff) && (run_rdata > longest_ff)) longest_in = run_rdata;
               if (k_ff == 2'd3) begin
                  state_in = ST_WFIN;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_WNB;
               end
            end
         end
         ST_WFIN: begin
            cell_we = 1'b1;
            if (sp_ff == '0) begin
               state_in = ST_SRD;
            end else begin
               sp_in    = sp_ff - CNT_BITS'(1);
               state_in = ST_WPOP;
            end
         end
         ST_WPOP: begin
            cr_in    = stk_rdata[ROW_BITS+COL_BITS-1:COL_BITS];
            cc_in    = stk_rdata[COL_BITS-1:0];
            state_in = ST_WCUR;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff    <= '0;
         best_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         best_ff  <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      ri_ff      <= ri_in;
      ci_ff      <= ci_in;
      cr_ff      <= cr_in;
      cc_ff      <= cc_in;
      hcur_ff    <= hcur_in;
      k_ff       <= k_in;
      longest_ff <= longest_in;
   end

   glpd_ram #(.WIDTH(HEIGHT_BITS + RUN_BITS), .DEPTH(CELL_DEPTH)) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .raddr (addr),
      .rdata (cell_rdata)
   );

   glpd_ram #(.WIDTH(ROW_BITS + COL_BITS), .DEPTH(CELL_DEPTH)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata ({cr_ff, cc_ff}),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   assign status.busy = state_ff != ST_IDLE;
   assign status.done = state_ff == ST_DONE;
   assign status.best = best_ff;
endmodule
`default_nettype wire

/* rtl/core/grid_longest_descent_path_unit.sv */
// Channel  | Handshake           | Payload
// input    | start, busy         | req_cell_height
// result   | rsp_valid (strobe)  | rsp_longest_run
// config   | csr_we              | csr_index, csr_wdata
//
// Loading takes one cycle per cell while busy is low; each cell is stored with
// its run length zeroed, so no clearing pass is needed between grids.
// The last cell of a grid starts the search and busy stays high while it scans
// each cell (read and check), fetches each cell visited, probes its neighbours (an
// in-grid probe is read and checked), stores a run length and pops the stack.
// busy falls in the cycle the result strobe shows; reset leaves the block idle.
// Results cannot be stalled; each strobe lasts exactly one cycle.
`default_nettype none
module grid_longest_descent_path_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [glpd_pkg::IN_BITS-1:0]       req_cell_height,
   output logic                                    rsp_valid,
   output logic [glpd_pkg::RUN_BITS-1:0]           rsp_longest_run,
   input  wire logic                               csr_we,
   input  wire logic [glpd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [glpd_pkg::DIM_BITS-1:0]      csr_wdata
);
   import glpd_pkg::*;

   logic [DIM_BITS-1:0]  rows_ff, cols_ff;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 rsp_valid_ff;
   logic [RUN_BITS-1:0]  rsp_run_ff;
   dims_type             dims;
   srch_status_type      status;
   logic                 accept, go, h_we;
   logic [CNT_BITS:0]    total;

   assign dims.rows = clamp_dim(rows_ff, DIM_BITS'(MAX_ROWS));
   assign dims.cols = clamp_dim(cols_ff, DIM_BITS'(MAX_COLS));
   assign total     = (CNT_BITS+1)'(dims.rows) * (CNT_BITS+1)'(dims.cols);
   assign busy      = status.busy;
   assign accept    = start && !busy;
   assign h_we      = accept && (cnt_ff < CNT_BITS'(CELL_DEPTH));
   assign go        = accept && ((CNT_BITS+1)'(cnt_ff) + (CNT_BITS+1)'(1) >= total);
   assign cnt_in    = go ? '0 : (accept ? cnt_ff + CNT_BITS'(1) : cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= DIM_BITS'(1);
         cols_ff      <= DIM_BITS'(1);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == REG_ROWS) rows_ff <= csr_wdata;
         if (csr_we && csr_index == REG_COLS) cols_ff <= csr_wdata;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= status.done;
      end
   end

   always_ff @(posedge clock) begin
      if (status.done) rsp_run_ff <= status.best;
   end

   glpd_search u_search (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .dims      (dims),
      .ld_we     (h_we),
      .ld_addr   (cnt_ff[ADDR_BITS-1:0]),
      .ld_height (req_cell_height[HEIGHT_BITS-1:0]),
      .status    (status)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_longest_run = rsp_run_ff;

`ifndef SYNTH
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_longest_run != '0) else $error("zero path length reported");
   a_busy_after_go: assert property (@(posedge clock) disable iff (reset)
      go |=> busy) else $error("search did not start");
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while searching");
`endif
endmodule
`default_nettype wire
